### hdl/csvfs_pkg.sv
// Shared constants and types for the CSV field splitter.
package csvfs_pkg;

	localparam int FIELD_BYTES = 64;
	localparam int ADDR_W      = $clog2(FIELD_BYTES);
	localparam int LEN_W       = $clog2(FIELD_BYTES + 1);

	localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
	localparam logic [7:0] QUOTE_BYTE    = 8'd34;
	localparam logic [7:0] SEP_RESET     = 8'd44;
	localparam logic [0:0] REG_SEPARATOR = 1'b0;

	// one closed field, handed from the front to the back
	typedef struct packed {
		logic             bank;
		logic             skip;
		logic [LEN_W-1:0] stop;
		logic             empty;
		logic             line_end;
		logic             truncated;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_done_t;

endpackage

### hdl/csvfs_front.sv
// Front end: accepts bytes, fills the current field bank and closes fields.
module csvfs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           separator_char,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	output csvfs_pkg::store_wr_t store_wr,
	output logic                 push,
	output csvfs_pkg::desc_t     push_desc,
	input  csvfs_pkg::bank_done_t done
);
	import csvfs_pkg::*;

	logic             wbank_q;
	logic [1:0]       busy_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [7:0]       first_q;
	logic [7:0]       last_q;

	logic accept;
	logic is_nl;
	logic is_sep;
	logic is_data;
	logic has_room;
	logic closing;
	logic quoted;

	assign in_ready = !busy_q[wbank_q];
	assign accept   = in_valid && in_ready;
	assign is_nl    = (in_byte == NEWLINE_BYTE);
	assign is_sep   = !is_nl && (in_byte == separator_char);
	assign is_data  = !is_nl && !is_sep;
	assign has_room = (len_q < LEN_W'(FIELD_BYTES));
	// a newline on an empty field emits nothing
	assign closing  = accept && (is_sep || (is_nl && len_q != '0));
	assign quoted   = (len_q >= LEN_W'(2)) && (first_q == QUOTE_BYTE)
		&& (last_q == QUOTE_BYTE);

	assign store_wr.en   = accept && is_data && has_room;
	assign store_wr.bank = wbank_q;
	assign store_wr.addr = len_q[ADDR_W-1:0];
	assign store_wr.data = in_byte;

	assign push                = closing;
	assign push_desc.bank      = wbank_q;
	assign push_desc.skip      = quoted;
	assign push_desc.stop      = quoted ? (len_q - LEN_W'(1)) : len_q;
	assign push_desc.empty     = (len_q == '0) || (quoted && len_q == LEN_W'(2));
	assign push_desc.line_end  = is_nl;
	assign push_desc.truncated = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			busy_q  <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (done.valid) begin
				busy_q[done.bank] <= 1'b0;
			end
			if (closing) begin
				// hand the bank over and switch to the other one
				busy_q[wbank_q] <= 1'b1;
				wbank_q         <= !wbank_q;
				len_q           <= '0;
				ovf_q           <= 1'b0;
			end else if (accept && is_nl) begin
				ovf_q <= 1'b0;
			end else if (accept && is_data) begin
				if (has_room) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			if (len_q == '0) begin
				first_q <= in_byte;
			end
			last_q <= in_byte;
		end
	end

endmodule

### hdl/csvfs_queue.sv
// Two-entry queue of closed-field descriptors between front and back.
module csvfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csvfs_pkg::desc_t push_desc,
	input  logic             pop,
	output logic             avail,
	output csvfs_pkg::desc_t head
);
	import csvfs_pkg::*;

	desc_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign avail = (count_q != 2'd0);
	assign head  = ent_q[rd_q];

	// at most two banks are busy, so the queue never overfills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_desc;
		end
	end

endmodule

### hdl/csvfs_back.sv
// Back end: holds the field banks and streams each closed field out.
module csvfs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csvfs_pkg::store_wr_t  store_wr,
	input  logic                  avail,
	input  csvfs_pkg::desc_t      head,
	output logic                  pop,
	output csvfs_pkg::bank_done_t done,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  field_empty,
	output logic                  field_last,
	output logic                  line_end,
	output logic                  truncated
);
	import csvfs_pkg::*;

	localparam int DEPTH = 2 * (2 ** ADDR_W);

	logic [7:0] mem [DEPTH];

	logic             active_q;
	logic             bank_q;
	logic [LEN_W-1:0] ptr_q;
	logic [LEN_W-1:0] stop_q;
	logic             empty_q;
	logic             le_q;
	logic             tr_q;

	logic       valid_s1;
	logic [7:0] rdata_s1;
	logic       empty_s1;
	logic       last_s1;
	logic       le_s1;
	logic       tr_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_empty_q;
	logic       out_last_q;
	logic       out_le_q;
	logic       out_tr_q;

	logic adv;
	logic issue;
	logic last_rd;

	assign adv        = valid_s1 && (!out_valid_q || out_ready);
	assign issue      = active_q && (!valid_s1 || adv);
	assign last_rd    = empty_q || ((ptr_q + LEN_W'(1)) == stop_q);
	assign pop        = !active_q && avail;
	// the last read is captured at issue, so the bank may be refilled after it
	assign done.valid = issue && last_rd;
	assign done.bank  = bank_q;

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem[{store_wr.bank, store_wr.addr}] <= store_wr.data;
		end
		if (issue && !empty_q) begin
			rdata_s1 <= mem[{bank_q, ptr_q[ADDR_W-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (issue && last_rd) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bank_q  <= head.bank;
			ptr_q   <= head.skip ? LEN_W'(1) : '0;
			stop_q  <= head.stop;
			empty_q <= head.empty;
			le_q    <= head.line_end;
			tr_q    <= head.truncated;
		end else if (issue) begin
			ptr_q <= ptr_q + LEN_W'(1);
		end
		if (issue) begin
			empty_s1 <= empty_q;
			last_s1  <= last_rd;
			le_s1    <= le_q;
			tr_s1    <= tr_q;
		end
		if (adv) begin
			out_byte_q  <= empty_s1 ? 8'd0 : rdata_s1;
			out_empty_q <= empty_s1;
			out_last_q  <= last_s1;
			out_le_q    <= le_s1;
			out_tr_q    <= tr_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign field_empty = out_empty_q;
	assign field_last  = out_last_q;
	assign line_end    = out_le_q;
	assign truncated   = out_tr_q;

endmodule

### hdl/csv_field_splitter.sv
// With the back end idle, a field's first result is presented after its closing byte
// passes the descriptor queue, back-end descriptor, read stage and output registers.
// Throughput: one input byte per cycle while a field bank is free; output streams
// one byte per cycle while m_tready is high, pausing between fields for a descriptor pop.
// Input stalls when both field banks hold fields whose bytes are not yet all read out.
// Reset (arst_n low) empties queue and output and sets the separator to comma.
module csv_field_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // field_last
	output logic [2:0]  m_tuser    // [0] field_empty, [1] line_end, [2] truncated
);
	import csvfs_pkg::*;

	logic [7:0] sep_q;
	store_wr_t  store_wr;
	logic       push;
	desc_t      push_desc;
	logic       pop;
	logic       avail;
	desc_t      head;
	bank_done_t done;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SEPARATOR) ? {24'd0, sep_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_SEPARATOR) begin
			sep_q <= pwdata[7:0];
		end
	end

	csvfs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.separator_char (sep_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_byte        (s_tdata),
		.store_wr       (store_wr),
		.push           (push),
		.push_desc      (push_desc),
		.done           (done)
	);

	csvfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	csvfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.store_wr    (store_wr),
		.avail       (avail),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.field_empty (m_tuser[0]),
		.field_last  (m_tlast),
		.line_end    (m_tuser[1]),
		.truncated   (m_tuser[2])
	);

endmodule
